>>> rtl/drs_pkg.sv
package drs_pkg;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    // Item kinds carried on s_tuser
    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_SERVICE = 1'b1;

    // Result status carried on m_tuser
    localparam logic [1:0] STAT_SERVED = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_ADDED  = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Scheduling policies; the unused code behaves as FCFS
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_SCAN = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLICY    = 2'd0;
    localparam logic [1:0] CFG_START_POS = 2'd1;
    localparam logic [1:0] CFG_START_DIR = 2'd2;

endpackage

>>> rtl/drs_qmem.sv
module drs_qmem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/disk_request_scheduler.sv
// Disk head scheduler. Pending track requests sit in arrival order in a single-port-write,
// registered-read queue memory of QUEUE_DEPTH entries. An add transaction, or a service
// transaction on an empty queue, goes straight to the result state and presents its result
// through the output register once that register is free. A service transaction on a
// non-empty queue searches one entry a cycle through the memory read port. A pass reads
// one entry for FCFS and all N pending entries for SSTF and SCAN, and SCAN makes a second
// pass when nothing lies in the head's direction. The chosen entry is then removed by
// moving every later entry down by one, one entry a cycle through the same port, before
// the result is presented. s_tready returns in the cycle the result is presented, so one
// transaction is in flight at a time; a finished result waits in the output register while
// the next transaction is accepted and worked on, and that one holds in its last cycle
// until the output register is free. A configuration write to the policy, start
// position or start direction register reloads the head position and direction.
module disk_request_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TRACK_BITS  = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input channel
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((TRACK_BITS+7)/8)*8-1:0]         s_tdata,   // track
    input  logic                                    s_tuser,   // mode
    // result channel
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // served_track, distance, position, moving_up
    output logic [((3*TRACK_BITS+8)/8)*8-1:0]       m_tdata,
    output logic [1:0]                              m_tuser,   // status
    // configuration
    input  logic                                    cfg_wen,
    input  logic [1:0]                              cfg_index,
    input  logic [TRACK_BITS-1:0]                   cfg_wdata
);

    localparam int TB     = TRACK_BITS;
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W  = ((3*TRACK_BITS+8)/8)*8;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    drs_pkg::state_t state_reg;

    // configuration and head state
    logic [1:0]       policy_reg;
    logic [TB-1:0]    start_pos_reg;
    logic             start_dir_reg;
    logic [TB-1:0]    head_pos_reg;
    logic             head_up_reg;
    logic [CNT_W-1:0] count_reg;

    // search pass
    logic [CNT_W-1:0] scan_ptr_reg;
    logic [CNT_W-1:0] scan_lim_reg;
    logic             scan_dir_reg;
    logic             scan_second_reg;
    logic             ev_valid_reg;
    logic [IDX_W-1:0] ev_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [TB-1:0]    best_track_reg;
    logic [TB-1:0]    best_gap_reg;

    // compaction
    logic [CNT_W-1:0] sh_ptr_reg;
    logic             sh_wvalid_reg;
    logic [IDX_W-1:0] sh_waddr_reg;

    // pending result and output register
    logic [1:0]       res_status_reg;
    logic [TB-1:0]    res_track_reg;
    logic [TB-1:0]    res_dist_reg;
    logic [TB-1:0]    res_pos_reg;
    logic             res_up_reg;
    logic             m_tvalid_reg;
    logic [1:0]       m_tuser_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [OUT_W-1:0] m_tdata_next;

    // memory port
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [TB-1:0]    mem_wr_data;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [TB-1:0]    mem_rd_data;

    logic             in_acc;
    logic [TB-1:0]    s_track;
    logic             is_sstf;
    logic             is_scan;
    logic             ev_gt;
    logic [TB-1:0]    ev_gap;
    logic             ev_ok;
    logic             ev_better;
    logic             pass_done;
    logic             pick_up;
    logic             out_free;

    assign s_tready = (state_reg == drs_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign s_track  = s_tdata[TB-1:0];
    assign is_sstf  = (policy_reg == drs_pkg::POL_SSTF);
    assign is_scan  = (policy_reg == drs_pkg::POL_SCAN);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // queue memory
    drs_qmem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TB)
    ) u_qmem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // write select: compaction move, or append on an add to a non-full queue; read select
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_reg[IDX_W-1:0];
        mem_wr_data = s_track;
        if (sh_wvalid_reg) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sh_waddr_reg;
            mem_wr_data = mem_rd_data;
        end else if (in_acc && s_tuser == drs_pkg::MODE_ADD && count_reg < DEPTH_C) begin
            mem_wr_en = 1'b1;
        end
        if (state_reg == drs_pkg::ST_SHIFT) begin
            mem_rd_addr = sh_ptr_reg[IDX_W-1:0];
        end else begin
            mem_rd_addr = scan_ptr_reg[IDX_W-1:0];
        end
    end

    // candidate evaluation of the entry just read
    always_comb begin
        ev_gt  = mem_rd_data > head_pos_reg;
        ev_gap = ev_gt ? (mem_rd_data - head_pos_reg) : (head_pos_reg - mem_rd_data);
        ev_ok  = is_scan ? (scan_dir_reg ? ev_gt : !ev_gt) : 1'b1;
        ev_better = ev_valid_reg && ev_ok && (!found_reg || ev_gap < best_gap_reg);
        pass_done = (scan_ptr_reg >= scan_lim_reg) && !ev_valid_reg;
        if (is_scan) begin
            pick_up = scan_dir_reg;
        end else if (is_sstf) begin
            pick_up = best_track_reg > head_pos_reg;
        end else begin
            pick_up = best_track_reg >= head_pos_reg;
        end
    end

    // result packing
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[0 +: TB]    = res_track_reg;
        m_tdata_next[TB +: TB]   = res_dist_reg;
        m_tdata_next[2*TB +: TB] = res_pos_reg;
        m_tdata_next[3*TB]       = res_up_reg;
    end

    // controller
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= drs_pkg::ST_IDLE;
            policy_reg      <= drs_pkg::POL_FCFS;
            start_pos_reg   <= '0;
            start_dir_reg   <= 1'b1;
            head_pos_reg    <= '0;
            head_up_reg     <= 1'b1;
            count_reg       <= '0;
            scan_ptr_reg    <= '0;
            scan_lim_reg    <= '0;
            scan_dir_reg    <= 1'b1;
            scan_second_reg <= 1'b0;
            ev_valid_reg    <= 1'b0;
            ev_idx_reg      <= '0;
            found_reg       <= 1'b0;
            best_idx_reg    <= '0;
            best_track_reg  <= '0;
            best_gap_reg    <= '0;
            sh_ptr_reg      <= '0;
            sh_wvalid_reg   <= 1'b0;
            sh_waddr_reg    <= '0;
            res_status_reg  <= drs_pkg::STAT_EMPTY;
            res_track_reg   <= '0;
            res_dist_reg    <= '0;
            res_pos_reg     <= '0;
            res_up_reg      <= 1'b1;
            m_tvalid_reg    <= 1'b0;
            m_tuser_reg     <= drs_pkg::STAT_EMPTY;
            m_tdata_reg     <= '0;
        end else begin
            sh_wvalid_reg <= 1'b0;
            // drop a taken result unless a new one replaces it below
            if (m_tvalid_reg && m_tready && state_reg != drs_pkg::ST_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                drs_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        res_track_reg <= '0;
                        res_dist_reg  <= '0;
                        res_pos_reg   <= head_pos_reg;
                        res_up_reg    <= head_up_reg;
                        if (s_tuser == drs_pkg::MODE_ADD) begin
                            state_reg <= drs_pkg::ST_RESULT;
                            if (count_reg < DEPTH_C) begin
                                count_reg      <= count_reg + ONE_C;
                                res_status_reg <= drs_pkg::STAT_ADDED;
                            end else begin
                                res_status_reg <= drs_pkg::STAT_FULL;
                            end
                        end else if (count_reg == '0) begin
                            state_reg      <= drs_pkg::ST_RESULT;
                            res_status_reg <= drs_pkg::STAT_EMPTY;
                        end else begin
                            state_reg       <= drs_pkg::ST_SCAN;
                            scan_ptr_reg    <= '0;
                            scan_lim_reg    <= (is_sstf || is_scan) ? count_reg : ONE_C;
                            scan_dir_reg    <= head_up_reg;
                            scan_second_reg <= 1'b0;
                            ev_valid_reg    <= 1'b0;
                            found_reg       <= 1'b0;
                            best_idx_reg    <= '0;
                        end
                    end
                end

                drs_pkg::ST_SCAN: begin
                    // issue one read a cycle, evaluate it the cycle after
                    if (scan_ptr_reg < scan_lim_reg) begin
                        scan_ptr_reg <= scan_ptr_reg + ONE_C;
                        ev_valid_reg <= 1'b1;
                        ev_idx_reg   <= scan_ptr_reg[IDX_W-1:0];
                    end else begin
                        ev_valid_reg <= 1'b0;
                    end
                    if (ev_better) begin
                        found_reg      <= 1'b1;
                        best_idx_reg   <= ev_idx_reg;
                        best_track_reg <= mem_rd_data;
                        best_gap_reg   <= ev_gap;
                    end
                    if (pass_done) begin
                        if (!found_reg && is_scan && !scan_second_reg) begin
                            // nothing this way: turn round and search again
                            scan_dir_reg    <= !scan_dir_reg;
                            scan_second_reg <= 1'b1;
                            scan_ptr_reg    <= '0;
                        end else begin
                            state_reg      <= drs_pkg::ST_SHIFT;
                            sh_ptr_reg     <= CNT_W'(best_idx_reg) + ONE_C;
                            res_status_reg <= drs_pkg::STAT_SERVED;
                            res_track_reg  <= best_track_reg;
                            res_dist_reg   <= best_gap_reg;
                            res_pos_reg    <= best_track_reg;
                            res_up_reg     <= pick_up;
                            head_pos_reg   <= best_track_reg;
                            head_up_reg    <= pick_up;
                        end
                    end
                end

                drs_pkg::ST_SHIFT: begin
                    // move each later entry down one place
                    if (sh_ptr_reg < count_reg) begin
                        sh_ptr_reg    <= sh_ptr_reg + ONE_C;
                        sh_wvalid_reg <= 1'b1;
                        sh_waddr_reg  <= IDX_W'(sh_ptr_reg - ONE_C);
                    end else begin
                        count_reg <= count_reg - ONE_C;
                        state_reg <= drs_pkg::ST_RESULT;
                    end
                end

                drs_pkg::ST_RESULT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= m_tdata_next;
                        state_reg    <= drs_pkg::ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= drs_pkg::ST_IDLE;
                end
            endcase

            // writes to the policy, start position or start direction register reload the head
            if (cfg_wen) begin
                unique case (cfg_index)
                    drs_pkg::CFG_POLICY: begin
                        policy_reg   <= cfg_wdata[1:0];
                        head_pos_reg <= start_pos_reg;
                        head_up_reg  <= start_dir_reg;
                    end
                    drs_pkg::CFG_START_POS: begin
                        start_pos_reg <= cfg_wdata;
                        head_pos_reg  <= cfg_wdata;
                        head_up_reg   <= start_dir_reg;
                    end
                    drs_pkg::CFG_START_DIR: begin
                        start_dir_reg <= cfg_wdata[0];
                        head_pos_reg  <= start_pos_reg;
                        head_up_reg   <= cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // queue occupancy stays within the memory
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");

    // occupancy moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + ONE_C
             || count_reg == $past(count_reg) - ONE_C))
        else $error("queue count jumped");

    // a served request leaves the head on its track
    a_served_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == drs_pkg::STAT_SERVED) |->
        (m_tdata[2*TB +: TB] == m_tdata[0 +: TB]))
        else $error("served position mismatch");

    // other results carry no track and no movement
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != drs_pkg::STAT_SERVED) |->
        (m_tdata[0 +: TB] == '0 && m_tdata[TB +: TB] == '0))
        else $error("non-served result carries movement");

endmodule

>>> sim/disk_request_scheduler_test.sv
`timescale 1ns / 100ps

module disk_request_scheduler_test;

    localparam int QDEPTH       = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 50;

    // Codes the package leaves unnamed
    localparam logic [1:0] POL_SPARE = 2'd3;    // behaves as FCFS
    localparam logic [1:0] CFG_SPARE = 2'd3;    // write is ignored

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] served;
        logic [15:0] travel;
        logic [15:0] position;
        logic        moving_up;
    } seek_outcome_t;

    // Clock and reset
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;

    // Input channel
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // track
    logic        s_tuser  = drs_pkg::MODE_ADD;   // mode

    // Result channel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // served_track, distance, position, moving_up
    logic [1:0]  m_tuser;           // status

    // Configuration port
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_index = drs_pkg::CFG_POLICY;
    logic [15:0] cfg_wdata = '0;

    // Scheduler state as predicted by the testbench
    logic [1:0]  sched_policy = drs_pkg::POL_FCFS;
    logic [15:0] start_track  = '0;
    logic        start_rising = 1'b1;
    logic [15:0] req_queue[$];
    logic [15:0] head_track   = '0;
    logic        head_rising  = 1'b1;

    seek_outcome_t outcome_q[$];

    int  err_cnt      = 0;
    int  cycle_cnt    = 0;
    bit  idle_on      = 1'b0;
    bit  hold_off_req = 1'b0;

    disk_request_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [15:0] seek_len(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Nearest pending request strictly above (rising) or at/below the head; -1 if none
    function automatic int nearest_toward(input logic rising);
        int          best;
        logic [15:0] best_len;
        logic        ok;
        best = -1;
        best_len = '0;
        for (int i = 0; i < req_queue.size(); i++) begin
            ok = rising ? (req_queue[i] > head_track) : (req_queue[i] <= head_track);
            if (ok && (best < 0 || seek_len(req_queue[i], head_track) < best_len)) begin
                best = i;
                best_len = seek_len(req_queue[i], head_track);
            end
        end
        return best;
    endfunction

    // Predicted response to one accepted transaction; updates the predicted state
    function automatic seek_outcome_t next_outcome(input logic mode, input logic [15:0] trk);
        seek_outcome_t r;
        int            pick;
        r = '0;
        pick = 0;
        if (mode == drs_pkg::MODE_ADD) begin
            if (req_queue.size() < QDEPTH) begin
                req_queue.push_back(trk);
                r.status = drs_pkg::STAT_ADDED;
            end else begin
                r.status = drs_pkg::STAT_FULL;
            end
        end else if (req_queue.size() == 0) begin
            r.status = drs_pkg::STAT_EMPTY;
        end else begin
            case (sched_policy)
                drs_pkg::POL_SSTF: begin
                    for (int i = 1; i < req_queue.size(); i++)
                        if (seek_len(req_queue[i], head_track) <
                            seek_len(req_queue[pick], head_track))
                            pick = i;
                    head_rising = (req_queue[pick] > head_track);
                end
                drs_pkg::POL_SCAN: begin
                    pick = nearest_toward(head_rising);
                    if (pick < 0) begin
                        head_rising = ~head_rising;
                        pick = nearest_toward(head_rising);
                    end
                    if (pick < 0)
                        pick = 0;
                end
                default: begin
                    head_rising = !(req_queue[0] < head_track);
                end
            endcase
            r.status = drs_pkg::STAT_SERVED;
            r.served = req_queue[pick];
            r.travel = seek_len(r.served, head_track);
            head_track = r.served;
            req_queue.delete(pick);
        end
        r.position  = head_track;
        r.moving_up = head_rising;
        return r;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            drs_pkg::CFG_POLICY:    sched_policy = val[1:0];
            drs_pkg::CFG_START_POS: start_track  = val;
            drs_pkg::CFG_START_DIR: start_rising = val[0];
            default:                return;
        endcase
        head_track  = start_track;
        head_rising = start_rising;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(8, 60);
    endfunction

    // Tracks biased towards the edges, the head and duplicates
    function automatic logic [15:0] pick_track();
        logic [15:0] t;
        case ($urandom_range(0, 19))
            0, 1:       t = 16'($urandom_range(0, 1));
            2, 3, 4:    t = 16'hFFFF - 16'($urandom_range(0, 1));
            5, 6, 7, 8: t = head_track + 16'($urandom_range(0, 16)) - 16'd8;
            9, 10, 11: begin
                if (req_queue.size() > 0)
                    t = req_queue[$urandom_range(0, req_queue.size() - 1)];
                else
                    t = 16'($urandom_range(0, 16'hFFFF));
            end
            default:    t = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return t;
    endfunction

    // One input transaction; valid stays high afterwards unless the next one idles first
    task automatic send_item(input logic mode, input logic [15:0] trk);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= trk;
        do @(posedge aclk); while (!s_tready);
        outcome_q.push_back(next_outcome(mode, trk));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_reg(idx, val);
        cfg_wen   <= 1'b0;
        @(posedge aclk);
    endtask

    // Result sink with random stalls and one long hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            err_cnt++;
        end
    endfunction

    // Compare every result transaction with the oldest prediction
    always @(posedge aclk) begin : check_results
        seek_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got status %0d data %h",
                         $time, m_tuser, m_tdata);
                err_cnt++;
            end else begin
                want = outcome_q.pop_front();
                check_field("status", 16'(want.status), 16'(m_tuser));
                check_field("served_track", want.served, m_tdata[15:0]);
                check_field("distance", want.travel, m_tdata[31:16]);
                check_field("position", want.position, m_tdata[47:32]);
                check_field("moving_up", 16'(want.moving_up), 16'(m_tdata[48]));
            end
        end
    end

    // Empty service, edge tracks, queue full, FCFS from reset
    task automatic test_limits();
        logic [15:0] fill[16] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFF,
                                  16'h8000, 16'h5555, 16'hAAAA, 16'h8001,
                                  16'h1234, 16'hFEDC, 16'h0001, 16'hFFFE,
                                  16'h4000, 16'hC000, 16'h7FFF, 16'h0F0F};
        idle_on = 1'b0;
        send_item(drs_pkg::MODE_SERVICE, 16'hFFFF);
        foreach (fill[i])
            send_item(drs_pkg::MODE_ADD, fill[i]);
        send_item(drs_pkg::MODE_ADD, 16'h3C3C);
        send_item(drs_pkg::MODE_SERVICE, 16'h0000);
        send_item(drs_pkg::MODE_SERVICE, 16'h0000);
        settle();
    endtask

    // SSTF with equal seeks, then SCAN downwards until it reverses and empties
    task automatic test_policies();
        write_reg(drs_pkg::CFG_START_POS, 16'h8000);
        write_reg(drs_pkg::CFG_POLICY, {14'h3FFF, drs_pkg::POL_SSTF});
        repeat (4) send_item(drs_pkg::MODE_SERVICE, 16'h0000);
        settle();
        write_reg(drs_pkg::CFG_START_DIR, 16'hFFFE);
        write_reg(drs_pkg::CFG_POLICY, {14'h0000, drs_pkg::POL_SCAN});
        repeat (11) send_item(drs_pkg::MODE_SERVICE, 16'h0000);
        settle();
    endtask

    // Unused policy code acts as FCFS; unused register index changes nothing
    task automatic test_spare_codes();
        write_reg(drs_pkg::CFG_POLICY, {14'h0000, POL_SPARE});
        send_item(drs_pkg::MODE_ADD, 16'h9000);
        send_item(drs_pkg::MODE_ADD, 16'h1000);
        send_item(drs_pkg::MODE_ADD, 16'h1000);
        send_item(drs_pkg::MODE_SERVICE, 16'h0000);
        send_item(drs_pkg::MODE_SERVICE, 16'h0000);
        settle();
        write_reg(CFG_SPARE, 16'h1234);
        send_item(drs_pkg::MODE_SERVICE, 16'h0000);
        settle();
    endtask

    // Sink holds off while the source keeps offering, so the input stalls
    task automatic test_output_hold();
        hold_off_req = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(i % 3 == 2 ? drs_pkg::MODE_SERVICE : drs_pkg::MODE_ADD, pick_track());
        settle();
    endtask

    // Phases of random traffic, each under a fresh setting
    task automatic test_random_traffic();
        int add_pct;
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph % 3 != 0);
            write_reg(drs_pkg::CFG_POLICY, {14'($urandom), 2'(ph % 4)});
            if (ph == 0)
                write_reg(drs_pkg::CFG_START_POS, 16'h0000);
            else if (ph == 1)
                write_reg(drs_pkg::CFG_START_POS, 16'hFFFF);
            else
                write_reg(drs_pkg::CFG_START_POS, 16'($urandom));
            write_reg(drs_pkg::CFG_START_DIR, 16'($urandom));
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_SPARE, 16'($urandom));
            case ($urandom_range(0, 2))
                0:       add_pct = 25;
                1:       add_pct = 50;
                default: add_pct = 75;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < add_pct)
                    send_item(drs_pkg::MODE_ADD, pick_track());
                else
                    send_item(drs_pkg::MODE_SERVICE, 16'($urandom));
            end
            settle();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_limits();
        test_policies();
        test_spare_codes();
        test_output_hold();
        test_random_traffic();
        settle();
        repeat (20) @(posedge aclk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
